// ===== src/cbor_isp_pkg.sv =====
// Shared types and constants for the CBOR item stream parser.
package cbor_isp_pkg;

  localparam int BYTE_W  = 8;
  localparam int ARG_W   = 64;
  localparam int CNT_W   = 65;
  localparam int MAJ_W   = 3;
  localparam int INFO_W  = 5;
  localparam int DEPTH_W = 5;
  localparam int ERR_W   = 2;
  localparam int PH_W    = 2;
  localparam int ARGN_W  = 4;

  localparam logic [PH_W-1:0] PH_HEAD    = 2'd0;
  localparam logic [PH_W-1:0] PH_ARG     = 2'd1;
  localparam logic [PH_W-1:0] PH_PAYLOAD = 2'd2;

  localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
  localparam logic [ERR_W-1:0] ERR_RESERVED = 2'd1;
  localparam logic [ERR_W-1:0] ERR_TRUNC    = 2'd2;
  localparam logic [ERR_W-1:0] ERR_DEEP     = 2'd3;

  localparam logic [INFO_W-1:0] INFO_ARG1 = 5'd24;
  localparam logic [INFO_W-1:0] INFO_ARG2 = 5'd25;
  localparam logic [INFO_W-1:0] INFO_ARG4 = 5'd26;
  localparam logic [INFO_W-1:0] INFO_ARG8 = 5'd27;

  localparam logic [MAJ_W-1:0] MAJ_BSTR  = 3'd2;
  localparam logic [MAJ_W-1:0] MAJ_TSTR  = 3'd3;
  localparam logic [MAJ_W-1:0] MAJ_ARRAY = 3'd4;
  localparam logic [MAJ_W-1:0] MAJ_MAP   = 3'd5;
  localparam logic [MAJ_W-1:0] MAJ_TAG   = 3'd6;

  typedef struct packed {
    logic accept;
    logic pop_step;
    logic load_out;
  } ctl_cmd_t;

  typedef struct packed {
    logic need_pop;
    logic pop_done;
  } dp_stat_t;

endpackage

// ===== src/cbor_isp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module cbor_isp_ram #(
  parameter int WIDTH = 65,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/cbor_isp_ctrl.sv =====
// Controller: handshakes, pop sequencing and output register hand-off.
module cbor_isp_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  cbor_isp_pkg::dp_stat_t stat,
  output cbor_isp_pkg::ctl_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_POP  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE) || ((state_r == ST_EMIT) && out_free);

  always_comb begin
    cmd.accept   = in_valid && in_ready;
    cmd.pop_step = (state_r == ST_POP);
    cmd.load_out = (state_r == ST_EMIT) && out_free;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.accept) begin
          state_nxt = stat.need_pop ? ST_POP : ST_EMIT;
        end
      end
      ST_POP: begin
        if (stat.pop_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          if (cmd.accept) begin
            state_nxt = stat.need_pop ? ST_POP : ST_EMIT;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== src/cbor_isp_dp.sv =====
// Datapath: head decode, payload skip, nesting stack and result registers.
module cbor_isp_dp #(
  parameter int STACK_DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  cbor_isp_pkg::ctl_cmd_t                   cmd,
  output cbor_isp_pkg::dp_stat_t                   stat,
  input  logic [cbor_isp_pkg::BYTE_W-1:0]          in_data_byte,
  input  logic                                     in_last_byte,
  output logic                                     out_head_done,
  output logic [cbor_isp_pkg::MAJ_W-1:0]           out_head_major,
  output logic [cbor_isp_pkg::INFO_W-1:0]          out_additional_info,
  output logic [cbor_isp_pkg::ARG_W-1:0]           out_argument,
  output logic                                     out_is_payload,
  output logic [cbor_isp_pkg::DEPTH_W-1:0]         out_nesting_depth,
  output logic                                     out_item_done,
  output logic [cbor_isp_pkg::ERR_W-1:0]           out_error_code
);

  localparam int LVL_W = $clog2(STACK_DEPTH + 1);
  localparam int AW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int ARG_W = cbor_isp_pkg::ARG_W;
  localparam int CNT_W = cbor_isp_pkg::CNT_W;

  // parser state
  logic [cbor_isp_pkg::PH_W-1:0]    phase_r, phase_nxt;
  logic [cbor_isp_pkg::ARGN_W-1:0]  arg_left_r, arg_left_nxt;
  logic [ARG_W-1:0]                 acc_r, acc_nxt;
  logic [cbor_isp_pkg::MAJ_W-1:0]   held_major_r, held_major_nxt;
  logic [cbor_isp_pkg::INFO_W-1:0]  held_info_r, held_info_nxt;
  logic [ARG_W-1:0]                 payload_left_r, payload_left_nxt;
  logic [LVL_W-1:0]                 level_r, level_nxt;
  logic [cbor_isp_pkg::ERR_W-1:0]   err_r, err_nxt;
  logic                             last_r, last_nxt;

  // result being formed
  logic                             h_hd_r, h_hd_nxt;
  logic [cbor_isp_pkg::MAJ_W-1:0]   h_major_r, h_major_nxt;
  logic [cbor_isp_pkg::INFO_W-1:0]  h_info_r, h_info_nxt;
  logic [ARG_W-1:0]                 h_arg_r, h_arg_nxt;
  logic                             h_pay_r, h_pay_nxt;
  logic [cbor_isp_pkg::DEPTH_W-1:0] h_depth_r, h_depth_nxt;
  logic                             h_idone_r, h_idone_nxt;
  logic [cbor_isp_pkg::ERR_W-1:0]   h_err_r, h_err_nxt;

  // output register
  logic                             o_hd_r;
  logic [cbor_isp_pkg::MAJ_W-1:0]   o_major_r;
  logic [cbor_isp_pkg::INFO_W-1:0]  o_info_r;
  logic [ARG_W-1:0]                 o_arg_r;
  logic                             o_pay_r;
  logic [cbor_isp_pkg::DEPTH_W-1:0] o_depth_r;
  logic                             o_idone_r;
  logic [cbor_isp_pkg::ERR_W-1:0]   o_err_r;

  // stack RAM
  logic             we;
  logic [AW-1:0]    waddr;
  logic [CNT_W-1:0] wdata;
  logic [AW-1:0]    raddr;
  logic [CNT_W-1:0] rdata;
  logic [LVL_W-1:0] lvl_m1, lvl_m2;

  assign lvl_m1 = level_r - LVL_W'(1);
  assign lvl_m2 = level_r - LVL_W'(2);
  // accept reads the top level; a pop step prefetches the one below it
  assign raddr  = cmd.pop_step ? lvl_m2[AW-1:0] : lvl_m1[AW-1:0];

  cbor_isp_ram #(
    .WIDTH (CNT_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    logic                           got;
    logic [ARG_W-1:0]               a;
    logic                           finish;
    logic                           commit;
    logic                           lst;
    logic                           push_req;
    logic [CNT_W-1:0]               push_val;
    logic [CNT_W-1:0]               cnt;
    logic [cbor_isp_pkg::ERR_W-1:0] err_fin;

    got      = 1'b0;
    a        = '0;
    finish   = 1'b0;
    commit   = 1'b0;
    lst      = 1'b0;
    push_req = 1'b0;
    push_val = '0;
    cnt      = '0;
    err_fin  = err_r;

    phase_nxt        = phase_r;
    arg_left_nxt     = arg_left_r;
    acc_nxt          = acc_r;
    held_major_nxt   = held_major_r;
    held_info_nxt    = held_info_r;
    payload_left_nxt = payload_left_r;
    level_nxt        = level_r;
    err_nxt          = err_r;
    last_nxt         = last_r;

    h_hd_nxt    = h_hd_r;
    h_major_nxt = h_major_r;
    h_info_nxt  = h_info_r;
    h_arg_nxt   = h_arg_r;
    h_pay_nxt   = h_pay_r;
    h_depth_nxt = h_depth_r;
    h_idone_nxt = h_idone_r;
    h_err_nxt   = h_err_r;

    we    = 1'b0;
    waddr = level_r[AW-1:0];
    wdata = '0;

    stat.need_pop = 1'b0;
    stat.pop_done = 1'b0;

    if (cmd.accept) begin
      lst         = in_last_byte;
      last_nxt    = in_last_byte;
      h_hd_nxt    = 1'b0;
      h_major_nxt = '0;
      h_info_nxt  = '0;
      h_arg_nxt   = '0;
      h_pay_nxt   = 1'b0;
      h_idone_nxt = 1'b0;
      if (err_r == cbor_isp_pkg::ERR_NONE) begin
        case (phase_r)
          cbor_isp_pkg::PH_HEAD: begin
            held_major_nxt = in_data_byte[7:5];
            held_info_nxt  = in_data_byte[4:0];
            if (held_info_nxt < cbor_isp_pkg::INFO_ARG1) begin
              got = 1'b1;
              a   = ARG_W'(held_info_nxt);
            end else if (held_info_nxt inside
                         {[cbor_isp_pkg::INFO_ARG1:cbor_isp_pkg::INFO_ARG8]}) begin
              phase_nxt = cbor_isp_pkg::PH_ARG;
              acc_nxt   = '0;
              case (held_info_nxt)
                cbor_isp_pkg::INFO_ARG1: arg_left_nxt = 4'd1;
                cbor_isp_pkg::INFO_ARG2: arg_left_nxt = 4'd2;
                cbor_isp_pkg::INFO_ARG4: arg_left_nxt = 4'd4;
                default:                 arg_left_nxt = 4'd8;
              endcase
            end else begin
              err_nxt = cbor_isp_pkg::ERR_RESERVED;
            end
          end
          cbor_isp_pkg::PH_ARG: begin
            acc_nxt      = {acc_r[ARG_W-cbor_isp_pkg::BYTE_W-1:0], in_data_byte};
            arg_left_nxt = arg_left_r - 4'd1;
            if (arg_left_nxt == '0) begin
              phase_nxt = cbor_isp_pkg::PH_HEAD;
              got       = 1'b1;
              a         = acc_nxt;
            end
          end
          cbor_isp_pkg::PH_PAYLOAD: begin
            h_pay_nxt        = 1'b1;
            payload_left_nxt = payload_left_r - ARG_W'(1);
            if (payload_left_nxt == '0) begin
              phase_nxt = cbor_isp_pkg::PH_HEAD;
              finish    = 1'b1;
            end
          end
          default: phase_nxt = cbor_isp_pkg::PH_HEAD;
        endcase

        if (got) begin
          h_hd_nxt    = 1'b1;
          h_major_nxt = held_major_nxt;
          h_info_nxt  = held_info_nxt;
          h_arg_nxt   = a;
          case (held_major_nxt)
            cbor_isp_pkg::MAJ_BSTR, cbor_isp_pkg::MAJ_TSTR: begin
              if (a == '0) begin
                finish = 1'b1;
              end else begin
                payload_left_nxt = a;
                phase_nxt        = cbor_isp_pkg::PH_PAYLOAD;
              end
            end
            cbor_isp_pkg::MAJ_ARRAY: begin
              if (a == '0) begin
                finish = 1'b1;
              end else begin
                push_req = 1'b1;
                push_val = {1'b0, a};
              end
            end
            cbor_isp_pkg::MAJ_MAP: begin
              if (a == '0) begin
                finish = 1'b1;
              end else begin
                push_req = 1'b1;
                push_val = {a, 1'b0};  // key plus value per pair
              end
            end
            cbor_isp_pkg::MAJ_TAG: begin
              // wraps the next item, nothing to count
            end
            default: finish = 1'b1;
          endcase
        end

        if (push_req) begin
          if (level_r >= LVL_W'(STACK_DEPTH)) begin
            err_nxt = cbor_isp_pkg::ERR_DEEP;
          end else begin
            we        = 1'b1;
            wdata     = push_val;
            level_nxt = level_r + LVL_W'(1);
          end
        end
      end

      if (finish) begin
        if (level_r == '0) begin
          h_idone_nxt = 1'b1;
        end else begin
          stat.need_pop = 1'b1;
        end
      end
      commit = !stat.need_pop;
    end else if (cmd.pop_step) begin
      lst   = last_r;
      cnt   = rdata - CNT_W'(1);
      waddr = lvl_m1[AW-1:0];
      if (cnt != '0) begin
        we            = 1'b1;
        wdata         = cnt;
        stat.pop_done = 1'b1;
      end else begin
        level_nxt = lvl_m1;
        if (level_nxt == '0) begin
          h_idone_nxt   = 1'b1;
          stat.pop_done = 1'b1;
        end
      end
      commit = stat.pop_done;
    end

    if (commit) begin
      err_fin = err_nxt;
      if (lst && (err_nxt == cbor_isp_pkg::ERR_NONE) &&
          ((phase_nxt != cbor_isp_pkg::PH_HEAD) || (level_nxt != '0) ||
           (held_major_nxt == cbor_isp_pkg::MAJ_TAG))) begin
        err_fin = cbor_isp_pkg::ERR_TRUNC;
      end
      h_err_nxt   = err_fin;
      h_depth_nxt = cbor_isp_pkg::DEPTH_W'(level_nxt);
      err_nxt     = err_fin;
      if (lst) begin
        phase_nxt        = cbor_isp_pkg::PH_HEAD;
        arg_left_nxt     = '0;
        acc_nxt          = '0;
        held_major_nxt   = '0;
        held_info_nxt    = '0;
        payload_left_nxt = '0;
        level_nxt        = '0;
        err_nxt          = cbor_isp_pkg::ERR_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= cbor_isp_pkg::PH_HEAD;
      arg_left_r     <= '0;
      acc_r          <= '0;
      held_major_r   <= '0;
      held_info_r    <= '0;
      payload_left_r <= '0;
      level_r        <= '0;
      err_r          <= cbor_isp_pkg::ERR_NONE;
      last_r         <= 1'b0;
    end else begin
      phase_r        <= phase_nxt;
      arg_left_r     <= arg_left_nxt;
      acc_r          <= acc_nxt;
      held_major_r   <= held_major_nxt;
      held_info_r    <= held_info_nxt;
      payload_left_r <= payload_left_nxt;
      level_r        <= level_nxt;
      err_r          <= err_nxt;
      last_r         <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    h_hd_r    <= h_hd_nxt;
    h_major_r <= h_major_nxt;
    h_info_r  <= h_info_nxt;
    h_arg_r   <= h_arg_nxt;
    h_pay_r   <= h_pay_nxt;
    h_depth_r <= h_depth_nxt;
    h_idone_r <= h_idone_nxt;
    h_err_r   <= h_err_nxt;
    if (cmd.load_out) begin
      o_hd_r    <= h_hd_r;
      o_major_r <= h_major_r;
      o_info_r  <= h_info_r;
      o_arg_r   <= h_arg_r;
      o_pay_r   <= h_pay_r;
      o_depth_r <= h_depth_r;
      o_idone_r <= h_idone_r;
      o_err_r   <= h_err_r;
    end
  end

  assign out_head_done       = o_hd_r;
  assign out_head_major      = o_major_r;
  assign out_additional_info = o_info_r;
  assign out_argument        = o_arg_r;
  assign out_is_payload      = o_pay_r;
  assign out_nesting_depth   = o_depth_r;
  assign out_item_done       = o_idone_r;
  assign out_error_code      = o_err_r;

endmodule

// ===== src/cbor_item_stream_parser.sv =====
// Result path: a byte's result is held in the h_ registers and loaded into the output
//   register in ST_EMIT, after ST_POP walks the stack when it ends a nested item.
// Throughput: one byte per cycle unless the output stalls or an open container count
//   is popped; popping the stack RAM (one level per cycle) holds off the next byte.
// Reset: synchronous, active low; clears parser state, nesting level, error and
//   out_valid. The stack RAM is not cleared; only levels pushed since are read.
module cbor_item_stream_parser #(
  parameter int STACK_DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [cbor_isp_pkg::BYTE_W-1:0]      in_data_byte,
  input  logic                                 in_last_byte,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_head_done,
  output logic [cbor_isp_pkg::MAJ_W-1:0]       out_head_major,
  output logic [cbor_isp_pkg::INFO_W-1:0]      out_additional_info,
  output logic [cbor_isp_pkg::ARG_W-1:0]       out_argument,
  output logic                                 out_is_payload,
  output logic [cbor_isp_pkg::DEPTH_W-1:0]     out_nesting_depth,
  output logic                                 out_item_done,
  output logic [cbor_isp_pkg::ERR_W-1:0]       out_error_code
);

  cbor_isp_pkg::ctl_cmd_t cmd;
  cbor_isp_pkg::dp_stat_t stat;

  cbor_isp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  cbor_isp_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .in_data_byte        (in_data_byte),
    .in_last_byte        (in_last_byte),
    .out_head_done       (out_head_done),
    .out_head_major      (out_head_major),
    .out_additional_info (out_additional_info),
    .out_argument        (out_argument),
    .out_is_payload      (out_is_payload),
    .out_nesting_depth   (out_nesting_depth),
    .out_item_done       (out_item_done),
    .out_error_code      (out_error_code)
  );

  // a reserved info byte never reports a head
  a_head_not_reserved: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_head_done |-> out_error_code != cbor_isp_pkg::ERR_RESERVED)
    else $error("head reported with reserved-info error");

  a_payload_not_head: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_payload |-> !out_head_done)
    else $error("payload byte also flagged as head");

  // top-level completion means every level has closed
  a_item_done_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item_done |-> out_nesting_depth == '0)
    else $error("item done with open levels");

  a_pop_holds: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop_step && !stat.pop_done |=> cmd.pop_step && !in_ready)
    else $error("pop sequence left early");

endmodule
